### rtl/core/lmx_pkg.sv
// ----------------------------------------------------------------------------
// lmx_pkg
// Shared types and constants for the logistic map byte XOR cipher unit.
// ----------------------------------------------------------------------------
package lmx_pkg;

  // Floating point unit operation codes
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_SEED   = 2'd1;
  localparam logic [1:0] REG_ROUNDS = 2'd2;

  // Register reset values
  localparam logic [63:0] GAIN_RESET = 64'h400F_FEB0_74A7_71C9;
  localparam logic [63:0] SEED_RESET = 64'h3FD3_3333_3333_3333;
  localparam logic [2:0]  ROUNDS_RESET = 3'd1;
  localparam logic [2:0]  ROUNDS_MAX   = 3'd5;

  // Double constants
  localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_255 = 64'h406F_E000_0000_0000;
  localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

  // Truncated keystream byte from the double x*255
  function automatic logic [7:0] key_byte(input logic [63:0] v);
    logic [10:0] e;
    logic [2:0]  k;
    logic [8:0]  tmp;
    logic [7:0]  res;
    e   = v[62:52];
    k   = 3'(e - 11'd1023);
    tmp = {1'b1, v[51:44]} >> (4'd8 - {1'b0, k});
    if (v[63] || (e == 11'd2047 && v[51:0] != 52'd0)) begin
      res = 8'd0;
    end else if (e >= 11'd1031) begin
      res = 8'd255;
    end else if (e < 11'd1023) begin
      res = 8'd0;
    end else begin
      res = tmp[7:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/lmx_fpu.sv
// ----------------------------------------------------------------------------
// lmx_fpu
// Iterative IEEE double multiply / subtract unit, round to nearest even.
// Multiply accumulates four 53x14 partial products; normalization
// shifts one bit per cycle.
// ----------------------------------------------------------------------------
module lmx_fpu (
  input  logic              clk,
  input  logic              rst,
  input  lmx_pkg::fpu_req_t req,
  output lmx_pkg::fpu_rsp_t rsp
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_SETUP  = 3'd1;
  localparam logic [2:0] F_ALIGN  = 3'd2;
  localparam logic [2:0] F_MULT   = 3'd3;
  localparam logic [2:0] F_NORM   = 3'd4;
  localparam logic [2:0] F_RSHIFT = 3'd5;
  localparam logic [2:0] F_ROUND  = 3'd6;

  logic [2:0]         state;
  logic               op;
  logic [63:0]        a_q, b_q;
  logic               sgn, zsign, st;
  logic signed [13:0] ex;
  logic [105:0]       m;
  logic [52:0]        ma, mb;
  logic [10:0]        ea_big, align_sh;
  logic               eff_sub;
  logic [1:0]         cnt;
  logic               done;
  logic [63:0]        result;

  // Operand unpack
  logic [10:0] ea_f, eb_f, eea, eeb;
  logic [52:0] ma53, mb53;
  logic        sa, sb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_big;

  always_comb begin
    ea_f   = a_q[62:52];
    eb_f   = b_q[62:52];
    sa     = a_q[63];
    sb     = (op == lmx_pkg::OP_SUB) ? ~b_q[63] : b_q[63];
    nan_a  = (ea_f == 11'h7FF) && (a_q[51:0] != 52'd0);
    nan_b  = (eb_f == 11'h7FF) && (b_q[51:0] != 52'd0);
    inf_a  = (ea_f == 11'h7FF) && (a_q[51:0] == 52'd0);
    inf_b  = (eb_f == 11'h7FF) && (b_q[51:0] == 52'd0);
    zero_a = (ea_f == 11'd0) && (a_q[51:0] == 52'd0);
    zero_b = (eb_f == 11'd0) && (b_q[51:0] == 52'd0);
    eea    = (ea_f == 11'd0) ? 11'd1 : ea_f;
    eeb    = (eb_f == 11'd0) ? 11'd1 : eb_f;
    ma53   = {ea_f != 11'd0, a_q[51:0]};
    mb53   = {eb_f != 11'd0, b_q[51:0]};
    a_big  = {eea, ma53} >= {eeb, mb53};
  end

  // Alignment of the smaller addend, with sticky jammed into the lsb
  logic [105:0] mb_full, mb_shift, mb_jam;
  logic         lost;

  always_comb begin
    mb_full  = {1'b0, mb, 52'd0};
    mb_shift = mb_full >> align_sh;
    lost     = (mb_shift << align_sh) != mb_full;
    mb_jam   = mb_shift | {105'd0, lost};
  end

  // Partial product for the current multiplier chunk, high chunk first
  logic [55:0]  mb56;
  logic [13:0]  chunk;
  logic [66:0]  pp;

  always_comb begin
    mb56  = {3'd0, mb};
    chunk = mb56[55 - 14 * cnt -: 14];
    pp    = {14'd0, ma} * {53'd0, chunk};
  end

  // Right shift into the subnormal range
  logic signed [13:0] rs_amt;
  logic [6:0]         rs_sh;
  logic [105:0]       m_rs;

  always_comb begin
    rs_amt = 14'sd1 - ex;
    rs_sh  = (rs_amt > 14'sd127) ? 7'd127 : rs_amt[6:0];
    m_rs   = m >> rs_sh;
  end

  // Round to nearest even and pack
  logic [52:0]        keep, m53;
  logic [53:0]        m54;
  logic               grd, stk, inc;
  logic signed [13:0] ex_r;
  logic [63:0]        packed_res;

  always_comb begin
    keep = m[105:53];
    grd  = m[52];
    stk  = (m[51:0] != 52'd0) | st;
    inc  = grd & (stk | keep[0]);
    m54  = {1'b0, keep} + {53'd0, inc};
    if (m54[53]) begin
      m53  = m54[53:1];
      ex_r = ex + 14'sd1;
    end else begin
      m53  = m54[52:0];
      ex_r = ex;
    end
    if (ex_r >= 14'sd2047) begin
      packed_res = {sgn, 11'h7FF, 52'd0};
    end else if (m53[52]) begin
      packed_res = {sgn, ex_r[10:0], m53[51:0]};
    end else begin
      packed_res = {sgn, 11'd0, m53[51:0]};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            op    <= req.op;
            a_q   <= req.a;
            b_q   <= req.b;
            state <= F_SETUP;
          end
        end
        F_SETUP: begin
          st <= 1'b0;
          if (op == lmx_pkg::OP_MUL) begin
            // Special operands of a product
            if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
              result <= lmx_pkg::DBL_QNAN;
              done   <= 1'b1;
              state  <= F_IDLE;
            end else if (inf_a || inf_b) begin
              result <= {sa ^ sb, 11'h7FF, 52'd0};
              done   <= 1'b1;
              state  <= F_IDLE;
            end else if (zero_a || zero_b) begin
              result <= {sa ^ sb, 63'd0};
              done   <= 1'b1;
              state  <= F_IDLE;
            end else begin
              sgn   <= sa ^ sb;
              ex    <= $signed({3'd0, eea}) + $signed({3'd0, eeb}) - 14'sd1022;
              ma    <= ma53;
              mb    <= mb53;
              m     <= '0;
              cnt   <= 2'd0;
              state <= F_MULT;
            end
          end else begin
            // Special operands of a difference
            if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
              result <= lmx_pkg::DBL_QNAN;
              done   <= 1'b1;
              state  <= F_IDLE;
            end else if (inf_a) begin
              result <= {sa, 11'h7FF, 52'd0};
              done   <= 1'b1;
              state  <= F_IDLE;
            end else if (inf_b) begin
              result <= {sb, 11'h7FF, 52'd0};
              done   <= 1'b1;
              state  <= F_IDLE;
            end else begin
              zsign   <= sa & sb;
              eff_sub <= sa != sb;
              if (a_big) begin
                sgn      <= sa;
                ma       <= ma53;
                mb       <= mb53;
                ea_big   <= eea;
                align_sh <= eea - eeb;
              end else begin
                sgn      <= sb;
                ma       <= mb53;
                mb       <= ma53;
                ea_big   <= eeb;
                align_sh <= eeb - eea;
              end
              state <= F_ALIGN;
            end
          end
        end
        F_ALIGN: begin
          ex    <= $signed({3'd0, ea_big}) + 14'sd1;
          m     <= eff_sub ? ({1'b0, ma, 52'd0} - mb_jam) : ({1'b0, ma, 52'd0} + mb_jam);
          state <= F_NORM;
        end
        F_MULT: begin
          // Accumulate one 53x14 partial product per cycle
          m   <= (m << 14) + {39'd0, pp};
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (m == '0 && !st) begin
            result <= {(op == lmx_pkg::OP_SUB) ? zsign : sgn, 63'd0};
            done   <= 1'b1;
            state  <= F_IDLE;
          end else if (!m[105] && ex > 14'sd1) begin
            m  <= m << 1;
            ex <= ex - 14'sd1;
          end else if (ex < 14'sd1) begin
            state <= F_RSHIFT;
          end else begin
            state <= F_ROUND;
          end
        end
        F_RSHIFT: begin
          m     <= m_rs;
          st    <= st | ((m_rs << rs_sh) != m);
          ex    <= 14'sd1;
          state <= F_ROUND;
        end
        F_ROUND: begin
          result <= packed_res;
          done   <= 1'b1;
          state  <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

### rtl/core/logistic_map_byte_xor_cipher_unit.sv
// ----------------------------------------------------------------------------
// logistic_map_byte_xor_cipher_unit
// Byte stream cipher: each byte is XORed with keystream bytes taken from a
// logistic map x = (r*x)*(1-x) run in IEEE double arithmetic.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         tdata = pixel_byte[7:0], tuser = first_of_image
// m_*       out        tdata = cipher_byte[7:0]
// cfg_*     in         index 0 gain_bits, 1 seed_bits, 2 rounds[2:0]
//
// Each round issues four operations to one shared double unit: r*x, 1-x,
// rx*om and y*255. Normalization shifts one bit at a time, so 1-x takes
// longer for every further bit that cancels when x is above one half, and
// subnormal values add one normalization shift per bit. A byte runs its
// rounds in turn and is then written to the output register before the
// next byte is accepted.
// Reset loads register defaults and sets the chaotic value to the seed.
// A finished byte waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
module logistic_map_byte_xor_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel_byte
  input  logic        s_tuser,   // [0] first_of_image
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] cipher_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [1:0] PH_RX = 2'd0;
  localparam logic [1:0] PH_OM = 2'd1;
  localparam logic [1:0] PH_Y  = 2'd2;
  localparam logic [1:0] PH_V  = 2'd3;

  logic [1:0]  state, phase;
  logic [63:0] gain_bits, seed_bits, chaos, rx, om;
  logic [2:0]  rounds, nleft, n_clamp;
  logic [7:0]  data;
  logic        start;

  lmx_pkg::fpu_req_t req;
  lmx_pkg::fpu_rsp_t rsp;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp round count into 1..5
  always_comb begin
    if (rounds == 3'd0) begin
      n_clamp = 3'd1;
    end else if (rounds > lmx_pkg::ROUNDS_MAX) begin
      n_clamp = lmx_pkg::ROUNDS_MAX;
    end else begin
      n_clamp = rounds;
    end
  end

  // Select operands for the current phase
  always_comb begin
    req.start = start;
    req.op    = lmx_pkg::OP_MUL;
    req.a     = gain_bits;
    req.b     = chaos;
    unique case (phase)
      PH_RX: begin
        req.a = gain_bits;
        req.b = chaos;
      end
      PH_OM: begin
        req.op = lmx_pkg::OP_SUB;
        req.a  = lmx_pkg::DBL_ONE;
        req.b  = chaos;
      end
      PH_Y: begin
        req.a = rx;
        req.b = om;
      end
      PH_V: begin
        req.a = chaos;
        req.b = lmx_pkg::DBL_255;
      end
      default: begin
      end
    endcase
  end

  lmx_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_bits <= lmx_pkg::GAIN_RESET;
      seed_bits <= lmx_pkg::SEED_RESET;
      rounds    <= lmx_pkg::ROUNDS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lmx_pkg::REG_GAIN:   gain_bits <= cfg_data;
        lmx_pkg::REG_SEED:   seed_bits <= cfg_data;
        lmx_pkg::REG_ROUNDS: rounds    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Round sequencer and output register
  always_ff @(posedge clk) begin
    start <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_RX;
      chaos    <= lmx_pkg::SEED_RESET;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the output once taken, unless a new byte replaces it now
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            data  <= s_tdata;
            nleft <= n_clamp;
            if (s_tuser) begin
              chaos <= seed_bits;
            end
            phase <= PH_RX;
            start <= 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (rsp.done) begin
            start <= 1'b1;
            unique case (phase)
              PH_RX: begin
                rx    <= rsp.result;
                phase <= PH_OM;
              end
              PH_OM: begin
                om    <= rsp.result;
                phase <= PH_Y;
              end
              PH_Y: begin
                chaos <= rsp.result;
                phase <= PH_V;
              end
              PH_V: begin
                data  <= data ^ lmx_pkg::key_byte(rsp.result);
                phase <= PH_RX;
                if (nleft == 3'd1) begin
                  start <= 1'b0;
                  state <= S_DONE;
                end else begin
                  nleft <= nleft - 3'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DONE: begin
          // Hand the byte over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= data;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
